@@ rtl/sefr_pkg.sv @@
// ----------------------------------------------------------------------------
// sefr_pkg
// Shared types and constants of the STX/ETX XOR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sefr_pkg;

    localparam int FRAME_MAX_DEF = 64;
    localparam int BYTE_W        = 8;

    localparam logic [BYTE_W-1:0] STX_CODE = 8'h02;
    localparam logic [BYTE_W-1:0] ETX_CODE = 8'h03;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_LEN,
        ST_BODY
    } rx_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_command;
        logic              last;
    } cell_item_t;

    typedef struct packed {
        logic       push;
        logic       flush;
        cell_item_t item;
    } chain_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sefr_cell.sv @@
// ----------------------------------------------------------------------------
// sefr_cell
// One cell of the payload chain: holds one frame byte with its flags and
// hands it to the next cell towards the head once that cell is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sefr_cell
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  flush,
    input  wire logic                  up_full,
    input  wire sefr_pkg::cell_item_t  up_item,
    input  wire logic                  release_item,
    output logic                       full,
    output sefr_pkg::cell_item_t       item
);

    logic                 full_reg;
    logic                 full_next;
    sefr_pkg::cell_item_t item_reg;
    logic                 take;

    assign take = !full_reg && up_full;

    always_comb
    begin
        priority if (flush)
        begin
            full_next = 1'b0;
        end
        else if (full_reg)
        begin
            full_next = !release_item;
        end
        else
        begin
            full_next = up_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= up_item;
        end
    end

    assign full = full_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

@@ rtl/sefr_parser.sv @@
// ----------------------------------------------------------------------------
// sefr_parser
// Frame parser: hunts for STX, checks the length, tracks the XOR check and
// feeds payload bytes into the chain; commits or flushes at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module sefr_parser
#(
    parameter int FRAME_MAX = sefr_pkg::FRAME_MAX_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [sefr_pkg::BYTE_W-1:0]   rx_byte,
    input  wire logic                          pop_last,
    output sefr_pkg::chain_ctl_t               ctl,
    output logic                               commit
);

    localparam int PW = $clog2(FRAME_MAX);
    localparam int TW = $clog2(FRAME_MAX + 1);
    localparam logic [sefr_pkg::BYTE_W-1:0] MAX8 = sefr_pkg::BYTE_W'(FRAME_MAX);

    sefr_pkg::rx_state_t            state_reg;
    sefr_pkg::rx_state_t            state_next;
    logic [PW-1:0]                  pos_reg;
    logic [PW-1:0]                  pos_next;
    logic [TW-1:0]                  total_reg;
    logic [TW-1:0]                  total_next;
    logic [sefr_pkg::BYTE_W-1:0]    check_reg;
    logic [sefr_pkg::BYTE_W-1:0]    check_next;
    logic [sefr_pkg::BYTE_W-1:0]    prev_reg;
    logic [sefr_pkg::BYTE_W-1:0]    prev_next;
    logic                           commit_reg;
    logic                           commit_next;
    logic [sefr_pkg::BYTE_W-1:0]    total8;
    logic                           len_ok;
    logic [TW-1:0]                  pos_ext;

    assign total8  = rx_byte + 8'd4;
    assign len_ok  = (total8 >= 8'd5) && (total8 <= MAX8);
    assign pos_ext = TW'(pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sefr_pkg::ST_HUNT;
            pos_reg    <= '0;
            total_reg  <= '0;
            check_reg  <= '0;
            commit_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            check_reg  <= check_next;
            commit_reg <= commit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        pos_next            = pos_reg;
        total_next          = total_reg;
        check_next          = check_reg;
        prev_next           = prev_reg;
        commit_next         = commit_reg;
        ctl.push            = 1'b0;
        ctl.flush           = 1'b0;
        ctl.item.data       = rx_byte;
        ctl.item.is_command = 1'b0;
        ctl.item.last       = 1'b0;

        if (pop_last)
        begin
            commit_next = 1'b0;
        end

        if (accept)
        begin
            prev_next = rx_byte;
            unique case (state_reg)
                sefr_pkg::ST_HUNT:
                begin
                    if (rx_byte == sefr_pkg::STX_CODE)
                    begin
                        state_next = sefr_pkg::ST_LEN;
                    end
                end
                sefr_pkg::ST_LEN:
                begin
                    if (len_ok)
                    begin
                        total_next = total8[TW-1:0];
                        check_next = rx_byte;
                        pos_next   = PW'(2);
                        state_next = sefr_pkg::ST_BODY;
                    end
                    else
                    begin
                        state_next = sefr_pkg::ST_HUNT;
                    end
                end
                sefr_pkg::ST_BODY:
                begin
                    pos_next            = pos_reg + 1'b1;
                    ctl.item.is_command = (pos_reg == PW'(2));
                    ctl.item.last       = (pos_ext == total_reg - TW'(3));
                    if (pos_ext < total_reg - TW'(2))
                    begin
                        check_next = check_reg ^ rx_byte;
                        ctl.push   = 1'b1;
                    end
                    if (pos_ext == total_reg - TW'(1))
                    begin
                        state_next = sefr_pkg::ST_HUNT;
                        if ((rx_byte == sefr_pkg::ETX_CODE) && (prev_reg == check_reg))
                        begin
                            commit_next = 1'b1;
                        end
                        else
                        begin
                            ctl.flush = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = sefr_pkg::ST_HUNT;
                end
            endcase
        end
    end

    assign commit = commit_reg;

endmodule

`default_nettype wire

@@ rtl/stx_etx_xor_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// stx_etx_xor_frame_receiver_core
// Deframes an STX / length / command / payload / XOR check / ETX byte stream.
//
// Input channel (in_valid, in_stall, rx_byte) takes one serial byte per
// transaction. Output channel (out_valid, out_stall, frame_byte, is_command,
// last) delivers the command and payload bytes of each good frame, is_command
// on the first, last on the final one. Bad frames give nothing.
// Payload bytes travel through a row of FRAME_MAX-3 cells towards the head;
// a byte moves one cell per cycle and only into an empty cell, and in_stall
// is high while the tail cell is full, so no byte is taken until the tail
// cell has handed on its byte.
// The first result is shown the cycle after ETX is taken once the command
// byte has reached the head cell; each later result is shown once the head
// cell has taken it from the cell behind. While results drain, in_stall is
// held high, so a frame costs len+4 input transactions and gives len results.
// A stalled output holds its result in the head cell.
// Reset empties the row and returns the parser to STX hunting.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_xor_frame_receiver_core
#(
    parameter int FRAME_MAX = sefr_pkg::FRAME_MAX_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sefr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sefr_pkg::BYTE_W-1:0]        frame_byte,
    output logic                               is_command,
    output logic                               last
);

    localparam int N = FRAME_MAX - 3;

    sefr_pkg::chain_ctl_t ctl;
    logic                 commit;
    logic                 accept;
    logic                 pop;
    logic                 pop_last;
    logic                 cell_full [N];
    sefr_pkg::cell_item_t cell_item [N];

    assign in_stall  = commit || cell_full[N-1];
    assign accept    = in_valid && !in_stall;
    assign out_valid = commit && cell_full[0];
    assign pop       = out_valid && !out_stall;
    assign pop_last  = pop && cell_item[0].last;

    sefr_parser
    #(
        .FRAME_MAX (FRAME_MAX)
    )
    u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .pop_last (pop_last),
        .ctl      (ctl),
        .commit   (commit)
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic                 up_full;
        sefr_pkg::cell_item_t up_item;
        logic                 release_item;

        if (i == N - 1)
        begin : g_tail
            assign up_full = ctl.push;
            assign up_item = ctl.item;
        end
        else
        begin : g_body
            assign up_full = cell_full[i+1];
            assign up_item = cell_item[i+1];
        end

        if (i == 0)
        begin : g_head
            assign release_item = pop;
        end
        else
        begin : g_inner
            assign release_item = !cell_full[i-1];
        end

        sefr_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .flush        (ctl.flush),
            .up_full      (up_full),
            .up_item      (up_item),
            .release_item (release_item),
            .full         (cell_full[i]),
            .item         (cell_item[i])
        );
    end

    assign frame_byte = cell_item[0].data;
    assign is_command = cell_item[0].is_command;
    assign last       = cell_item[0].last;

endmodule

`default_nettype wire

@@ rtl/sefr_checker.sv @@
// ----------------------------------------------------------------------------
// sefr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sefr_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [sefr_pkg::BYTE_W-1:0]   rx_byte,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [sefr_pkg::BYTE_W-1:0]   frame_byte,
    input  wire logic                          is_command,
    input  wire logic                          last
);

    logic mid_run_reg;
    logic mid_run_next;

    always_comb
    begin
        mid_run_next = mid_run_reg;
        if (out_valid && !out_stall)
        begin
            mid_run_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_run_reg <= 1'b0;
        end
        else
        begin
            mid_run_reg <= mid_run_next;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(rx_byte))
        else $error("stalled input transaction changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte)
            && $stable(is_command) && $stable(last))
        else $error("stalled result changed");

    a_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a frame drains");

    a_cmd_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mid_run_reg |-> is_command)
        else $error("run does not open with the command byte");

    a_cmd_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_run_reg |-> !is_command)
        else $error("command flag inside a run");

endmodule

bind stx_etx_xor_frame_receiver_core sefr_checker u_sefr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .is_command (is_command),
    .last       (last)
);

`default_nettype wire
